### hw/rtl/gde_pkg.sv
// Shared types and constants for the GPIO debounce event queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gde_pkg;

  // Request kinds carried in the input beat's tuser.
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_MODE = 2'd1,
    REQ_EDGE     = 2'd2,
    REQ_DRAIN    = 2'd3
  } req_t;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_PRESS   = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  localparam int TICKS_W     = 8;
  localparam int PIN_IN_W    = 5;
  localparam int PIN_FIELD_W = 6;
  localparam int CODE_W      = 8;
  localparam int COUNT_W     = 6;

  localparam logic [TICKS_W-1:0] PRESS_RESET   = 8'd3;
  localparam logic [TICKS_W-1:0] RELEASE_RESET = 8'd20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input beat
    logic scan_step;    // debounce the pin under the scan pointer
    logic set_mode;     // apply the captured pin mode
    logic direct_edge;  // queue a direct edge event
    logic rd_issue;     // read the event store at the drain pointer
    logic load_beat;    // load a drained entry into the output register
    logic load_empty;   // load the empty-drain beat
    logic clear_fill;   // empty the event store after a drain
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;    // scan pointer is at the last pin
    logic rd_last;      // drain pointer is at the last stored entry
    logic fill_empty;   // event store holds nothing
    logic slot_free;    // output register can take a beat this cycle
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/gde_ctrl.sv
// Controller state machine for the GPIO debounce event queue.
// Depends on gde_pkg for the request codes and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module gde_ctrl import gde_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire req_t in_req,
  input  wire sts_t sts,
  output logic      in_ready,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SET,
    ST_EDGE,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_DRAIN_EMPTY
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    unique case (state)
      ST_IDLE: ;
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_SET:   cmd.set_mode = 1'b1;
      ST_EDGE:  cmd.direct_edge = 1'b1;
      ST_DRAIN_RD: cmd.rd_issue = 1'b1;
      ST_DRAIN_WR: begin
        cmd.load_beat  = sts.slot_free;
        cmd.clear_fill = sts.slot_free && sts.rd_last;
      end
      ST_DRAIN_EMPTY: cmd.load_empty = sts.slot_free;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req)
              REQ_TICK:     state <= ST_SCAN;
              REQ_SET_MODE: state <= ST_SET;
              REQ_EDGE:     state <= ST_EDGE;
              REQ_DRAIN:    state <= sts.fill_empty ? ST_DRAIN_EMPTY : ST_DRAIN_RD;
              default:      state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (sts.scan_done) state <= ST_IDLE;
        end
        ST_SET:  state <= ST_IDLE;
        ST_EDGE: state <= ST_IDLE;
        ST_DRAIN_RD: state <= ST_DRAIN_WR;
        ST_DRAIN_WR: begin
          if (sts.slot_free) begin
            state <= sts.rd_last ? ST_IDLE : ST_DRAIN_RD;
          end
        end
        ST_DRAIN_EMPTY: begin
          if (sts.slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gde_datapath.sv
// Datapath for the GPIO debounce event queue: pin mode state, hold counters,
// the shared per-pin debounce step, the event store and the output register.
// Depends on gde_pkg for constants and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module gde_datapath import gde_pkg::*; #(
  parameter int NUM_PINS    = 30,
  parameter int EVENT_DEPTH = 60
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic [PIN_IN_W-1:0] in_pin,
  input  wire logic                in_rise,
  input  wire logic                in_fall,
  input  wire logic                in_deb,
  input  wire logic [NUM_PINS-1:0] in_raw,
  input  wire logic [TICKS_W-1:0]  press_ticks,
  input  wire logic [TICKS_W-1:0]  release_ticks,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_entry,
  output logic [CODE_W-1:0]        out_code,
  output logic                     out_last
);

  localparam int PIN_W  = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int ADDR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int FILL_W = $clog2(EVENT_DEPTH + 1);

  // Captured input beat.
  logic [PIN_IN_W-1:0] cap_pin;
  logic                cap_rise;
  logic                cap_fall;
  logic                cap_deb;
  logic [NUM_PINS-1:0] cap_raw;

  // Pin mode and debounce state.
  logic [NUM_PINS-1:0] deb_level;
  logic [NUM_PINS-1:0] deb_rise_en;
  logic [NUM_PINS-1:0] deb_fall_en;
  logic [NUM_PINS-1:0] dir_rise_en;
  logic [NUM_PINS-1:0] dir_fall_en;
  logic [TICKS_W-1:0]  hold_counter [NUM_PINS];

  logic [PIN_W-1:0]    scan_ptr;
  logic [ADDR_W-1:0]   drain_ptr;
  logic [FILL_W-1:0]   fill;

  logic [CODE_W-1:0]   event_store [EVENT_DEPTH];
  logic [CODE_W-1:0]   rd_data;

  // Combinational step results.
  logic                scan_ren, scan_fen, scan_raw, scan_deb;
  logic [TICKS_W-1:0]  hold_cur, hold_next;
  logic                lvl_flip;
  logic                push_req;
  logic [CODE_W-1:0]   push_code;
  logic                push_en;
  logic                pin_ok;
  logic [PIN_W-1:0]    pin_idx;
  logic [NUM_PINS-1:0] pin_sel;
  logic                dir_set, deb_set;
  logic                rd_last;

  assign pin_ok  = {1'b0, cap_pin} < (PIN_IN_W + 1)'(NUM_PINS);
  assign pin_idx = cap_pin[PIN_W-1:0];
  assign pin_sel = NUM_PINS'(1) << pin_idx;
  assign dir_set = cmd.set_mode && pin_ok && (cap_rise || cap_fall) && !cap_deb;
  assign deb_set = cmd.set_mode && pin_ok && (cap_rise || cap_fall) && cap_deb;

  assign scan_ren = deb_rise_en[scan_ptr];
  assign scan_fen = deb_fall_en[scan_ptr];
  assign scan_raw = cap_raw[scan_ptr];
  assign scan_deb = deb_level[scan_ptr];
  assign hold_cur = hold_counter[scan_ptr];

  assign rd_last = (FILL_W'(drain_ptr) + FILL_W'(1)) == fill;

  assign sts.scan_done  = (scan_ptr == PIN_W'(NUM_PINS - 1));
  assign sts.rd_last    = rd_last;
  assign sts.fill_empty = (fill == '0);
  assign sts.slot_free  = !out_valid || out_ready;

  // Debounce step for one pin, and the direct edge event.
  always_comb begin
    hold_next = hold_cur;
    lvl_flip  = 1'b0;
    push_req  = 1'b0;
    push_code = '0;
    if (cmd.scan_step && (scan_ren || scan_fen)) begin
      if (scan_raw == scan_deb) begin
        hold_next = scan_deb ? release_ticks : press_ticks;
      end else if (hold_cur <= TICKS_W'(1)) begin
        lvl_flip  = 1'b1;
        hold_next = scan_raw ? release_ticks : press_ticks;
        push_req  = (scan_raw && scan_ren) || (!scan_raw && scan_fen);
        push_code = {!scan_raw && scan_fen, scan_raw && scan_ren,
                     PIN_FIELD_W'(scan_ptr)};
      end else begin
        hold_next = hold_cur - TICKS_W'(1);
      end
    end else if (cmd.direct_edge && pin_ok) begin
      push_req  = (cap_rise && dir_rise_en[pin_idx]) || (cap_fall && dir_fall_en[pin_idx]);
      push_code = {cap_fall && dir_fall_en[pin_idx], cap_rise && dir_rise_en[pin_idx],
                   PIN_FIELD_W'(cap_pin)};
    end
  end

  assign push_en = push_req && (fill < FILL_W'(EVENT_DEPTH));

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_pin  <= in_pin;
      cap_rise <= in_rise;
      cap_fall <= in_fall;
      cap_deb  <= in_deb;
      cap_raw  <= in_raw;
    end
  end

  // Pin modes, debounced levels and hold counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      deb_level   <= '0;
      deb_rise_en <= '0;
      deb_fall_en <= '0;
      dir_rise_en <= '0;
      dir_fall_en <= '0;
      for (int i = 0; i < NUM_PINS; i++) hold_counter[i] <= PRESS_RESET;
    end else begin
      if (cmd.set_mode && pin_ok) begin
        dir_rise_en <= (dir_rise_en & ~pin_sel) | ({NUM_PINS{dir_set && cap_rise}} & pin_sel);
        dir_fall_en <= (dir_fall_en & ~pin_sel) | ({NUM_PINS{dir_set && cap_fall}} & pin_sel);
        deb_rise_en <= (deb_rise_en & ~pin_sel) | ({NUM_PINS{deb_set && cap_rise}} & pin_sel);
        deb_fall_en <= (deb_fall_en & ~pin_sel) | ({NUM_PINS{deb_set && cap_fall}} & pin_sel);
      end
      if (deb_set) begin
        deb_level[pin_idx] <= cap_raw[pin_idx];
      end else if (lvl_flip) begin
        deb_level[scan_ptr] <= scan_raw;
      end
      if (cmd.scan_step) begin
        hold_counter[scan_ptr] <= hold_next;
      end
    end
  end

  // Scan pointer, drain pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr  <= '0;
      drain_ptr <= '0;
      fill      <= '0;
    end else begin
      if (cmd.scan_step) begin
        scan_ptr <= sts.scan_done ? '0 : scan_ptr + PIN_W'(1);
      end
      if (cmd.clear_fill) begin
        fill      <= '0;
        drain_ptr <= '0;
      end else begin
        if (push_en) fill <= fill + FILL_W'(1);
        if (cmd.load_beat) drain_ptr <= drain_ptr + ADDR_W'(1);
      end
    end
  end

  // Event store: written at the fill count, read at the drain pointer.
  always_ff @(posedge clk) begin
    if (push_en) begin
      event_store[fill[ADDR_W-1:0]] <= push_code;
    end
    if (cmd.rd_issue) begin
      rd_data <= event_store[drain_ptr];
    end
  end

  // Output register: one beat waits here while the next item can start.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_beat || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_beat) begin
      out_count <= COUNT_W'(fill);
      out_entry <= 1'b1;
      out_code  <= rd_data;
      out_last  <= rd_last;
    end else if (cmd.load_empty) begin
      out_count <= '0;
      out_entry <= 1'b0;
      out_code  <= '0;
      out_last  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gpio_debounce_event_queue.sv
// Top level of the GPIO debounce event queue: stream ports, APB registers,
// controller and datapath. Depends on gde_pkg, gde_ctrl and gde_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Watches NUM_PINS input pins and queues edge events in an EVENT_DEPTH-entry
// store. One input beat is handled at a time. A tick accepts the beat, then
// takes every pin in turn through the single shared debounce step. A drain
// reads each stored event from the event store's registered port, then loads
// it into the output register, or loads one empty beat when the store is
// empty; m_axis_tready can hold a beat back. The output register lets the
// next input beat be accepted while the last result is still waiting. The
// store needs no clearing pass after reset: a fill count tracks which entries
// are live.
module gpio_debounce_event_queue import gde_pkg::*; #(
  parameter int NUM_PINS    = 30,
  parameter int EVENT_DEPTH = 60,
  localparam int IN_W       = ((PIN_IN_W + 3 + NUM_PINS + 7) / 8) * 8,
  localparam int OUT_W      = ((COUNT_W + CODE_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: pin, rise_flag, fall_flag, debounce_on, raw_levels (from bit 0 up)
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // tuser: req_type
  input  wire logic [1:0]       s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // tdata: event_count, event_code (from bit 0 up)
  output logic [OUT_W-1:0]      m_axis_tdata,
  // tuser: entry_valid
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  // Configuration port.
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int RAW_LSB = PIN_IN_W + 3;

  logic [TICKS_W-1:0] press_ticks;
  logic [TICKS_W-1:0] release_ticks;
  logic [COUNT_W-1:0] out_count;
  logic [CODE_W-1:0]  out_code;
  cmd_t               cmd;
  sts_t               sts;

  // Register writes and reads.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= PRESS_RESET;
      release_ticks <= RELEASE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_PRESS:   press_ticks   <= pwdata[TICKS_W-1:0];
        REG_RELEASE: release_ticks <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PRESS:   prdata = 32'(press_ticks);
      REG_RELEASE: prdata = 32'(release_ticks);
      default:     prdata = '0;
    endcase
  end

  // Sequencer.
  gde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_req   (req_t'(s_axis_tuser)),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  // Pin state, event store and output register.
  gde_datapath #(
    .NUM_PINS    (NUM_PINS),
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_pin        (s_axis_tdata[PIN_IN_W-1:0]),
    .in_rise       (s_axis_tdata[PIN_IN_W]),
    .in_fall       (s_axis_tdata[PIN_IN_W+1]),
    .in_deb        (s_axis_tdata[PIN_IN_W+2]),
    .in_raw        (s_axis_tdata[RAW_LSB+NUM_PINS-1:RAW_LSB]),
    .press_ticks   (press_ticks),
    .release_ticks (release_ticks),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_count     (out_count),
    .out_entry     (m_axis_tuser),
    .out_code      (out_code),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({out_code, out_count});

  // An empty-drain beat carries no count and no code and ends the drain.
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("empty drain beat malformed");

  // A beat that carries an event reports a nonzero event count.
  a_entry_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[COUNT_W-1:0] != '0))
    else $error("event beat with zero count");

  // Once a drain is accepted, no further input beat is taken the next cycle.
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_DRAIN) |=> !s_axis_tready)
    else $error("input accepted during drain");

endmodule

`default_nettype wire
